[rtl/pctb_pkg.sv]
// Shared types, constants and a helper function for the per-channel token bucket block.
`default_nettype none

package pctb_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CH_W   = 3;
  localparam int unsigned TOK_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PROD_W = TIME_W + TOK_W;

  // Configuration port geometry.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Defaults and reset values.
  localparam int unsigned         CHANNEL_COUNT_DEF = 8;
  localparam int unsigned         QUEUE_DEPTH       = 2;
  localparam logic [TOK_W-1:0]    CAP_RESET         = TOK_W'(256);
  localparam logic [TIME_W-1:0]   PERIOD_RESET      = TIME_W'(60000);

  // Command codes as they arrive on the input port.
  typedef enum logic [CMD_W-1:0] {
    CMD_TAKE   = 2'd0,
    CMD_REFUND = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_PERIOD   = 1'b1
  } reg_e;

  // Work classes that the front end hands to the back end.
  typedef enum logic [1:0] {
    OP_TAKE,
    OP_REFUND,
    OP_CLEAR,
    OP_IGNORE
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_APPLY,
    S_GRANT
  } back_state_e;

  // One classified word waiting in the queue.
  typedef struct packed {
    op_e               op;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] now_ms;
    logic [TOK_W-1:0]  amount;
  } item_t;

  // Live configuration seen by the back end.
  typedef struct packed {
    logic [TOK_W-1:0]  capacity;
    logic [TIME_W-1:0] period;
  } cfg_t;

  // Adds up to extra tokens without passing capacity; a count already
  // above capacity is left as it is.
  function automatic logic [TOK_W-1:0] top_up(input logic [TOK_W-1:0]  tok,
                                              input logic [PROD_W-1:0] extra,
                                              input logic [TOK_W-1:0]  cap);
    logic [TOK_W-1:0] room;
    room = (tok < cap) ? (cap - tok) : '0;
    if (extra < PROD_W'(room)) begin
      return tok + extra[TOK_W-1:0];
    end
    return tok + room;
  endfunction

endpackage

`default_nettype wire

[rtl/pctb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pctb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/pctb_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module pctb_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pctb_pkg::PROD_W-1:0]  dividend_i,
  input  wire logic [pctb_pkg::TIME_W-1:0]  divisor_i,
  output      logic                         done_o,
  output      logic [pctb_pkg::PROD_W-1:0]  quotient_o
);

  localparam int unsigned PW    = pctb_pkg::PROD_W;
  localparam int unsigned DW    = pctb_pkg::TIME_W;
  localparam int unsigned CNT_W = $clog2(PW + 1);

  logic [PW-1:0]    shift_q, shift_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dsr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DW:0]      partial;
  logic [DW:0]      diff;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign partial = {rem_q, shift_q[PW-1]};
  assign diff    = partial - {1'b0, dsr_q};

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      cnt_d   = CNT_W'(PW);
      run_d   = 1'b1;
    end else if (run_q) begin
      if (!diff[DW]) begin
        rem_d   = diff[DW-1:0];
        shift_d = {shift_q[PW-2:0], 1'b1};
      end else begin
        rem_d   = partial[DW-1:0];
        shift_d = {shift_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath; a zero divisor is treated as one.
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    if (start_i) begin
      dsr_q <= (divisor_i == '0) ? DW'(1) : divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

endmodule

`default_nettype wire

[rtl/pctb_front.sv]
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none

module pctb_front #(
  parameter int unsigned CHANNEL_COUNT = pctb_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [pctb_pkg::CMD_W-1:0]   command_i,
  input  wire logic [pctb_pkg::CH_W-1:0]    channel_i,
  input  wire logic [pctb_pkg::TIME_W-1:0]  now_ms_i,
  input  wire logic [pctb_pkg::TOK_W-1:0]   amount_i,
  input  wire logic                         pop_i,
  output      pctb_pkg::item_t              item_o,
  output      logic                         item_valid_o
);

  localparam int unsigned DEPTH = pctb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pctb_pkg::item_t  slot_q [DEPTH];
  pctb_pkg::item_t  in_item;
  pctb_pkg::op_e    op;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             in_range;
  logic             push;
  logic             pop;

  // Classify the incoming word; take and refund commands to missing channels do nothing.
  assign in_range = 32'(channel_i) < CHANNEL_COUNT;

  always_comb begin
    case (pctb_pkg::cmd_e'(command_i))
      pctb_pkg::CMD_TAKE:   op = in_range ? pctb_pkg::OP_TAKE : pctb_pkg::OP_IGNORE;
      pctb_pkg::CMD_REFUND: op = in_range ? pctb_pkg::OP_REFUND : pctb_pkg::OP_IGNORE;
      pctb_pkg::CMD_CLEAR:  op = pctb_pkg::OP_CLEAR;
      default:              op = pctb_pkg::OP_IGNORE;
    endcase
  end

  assign in_item = '{op: op, channel: channel_i, now_ms: now_ms_i, amount: amount_i};

  // Queue pointers and fill level.
  assign busy = (count_q == CNT_W'(DEPTH));
  assign push = start && !busy;
  assign pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

  assign item_o       = slot_q[rd_ptr_q];
  assign item_valid_o = (count_q != '0);

endmodule

`default_nettype wire

[rtl/pctb_back.sv]
// Back end: bucket table, refill arithmetic and grant sequencing.
`default_nettype none

module pctb_back #(
  parameter int unsigned CHANNEL_COUNT = pctb_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pctb_pkg::cfg_t               cfg_i,
  input  wire pctb_pkg::item_t              item_i,
  input  wire logic                         item_valid_i,
  output      logic                         pop_o,
  output      logic                         done_o,
  output      logic [pctb_pkg::TOK_W-1:0]   granted_o,
  output      logic [pctb_pkg::TOK_W-1:0]   tokens_left_o
);

  localparam int unsigned IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned TW     = pctb_pkg::TOK_W;
  localparam int unsigned SW     = pctb_pkg::TIME_W;
  localparam int unsigned PW     = pctb_pkg::PROD_W;
  localparam int unsigned ENTRY_W = SW + TW;

  pctb_pkg::back_state_e  state_q, state_d;
  pctb_pkg::op_e          op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [IDX_W-1:0]       in_idx;
  logic [31:0]            ch_ext;
  logic [SW-1:0]          now_q;
  logic [TW-1:0]          amt_q;
  logic [TW-1:0]          tok_q;
  logic [SW-1:0]          stamp_q;
  logic [PW-1:0]          prod_q;
  logic [CHANNEL_COUNT-1:0] valid_q;
  logic                   done_q;
  logic [TW-1:0]          granted_q, left_q;

  logic                   ram_re, ram_we;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [TW-1:0]          rd_tok;
  logic [SW-1:0]          rd_stamp;
  logic [SW-1:0]          elapsed;
  logic [TW-1:0]          grant;
  logic                   div_start, div_done;
  logic [PW-1:0]          quot;

  // Bucket index from the channel field.
  assign ch_ext = 32'(item_i.channel);
  assign in_idx = ch_ext[IDX_W-1:0];

  assign rd_tok   = ram_rdata[TW-1:0];
  assign rd_stamp = ram_rdata[ENTRY_W-1:TW];
  assign elapsed  = now_q - rd_stamp;
  assign grant    = (op_q == pctb_pkg::OP_TAKE) ? ((tok_q < amt_q) ? tok_q : amt_q) : '0;

  // Token counts and stamps; entries are only read once their valid bit is set.
  pctb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNEL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({stamp_q, tok_q - grant}),
    .re_i    (ram_re),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // Refill amount: elapsed * capacity / period.
  pctb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (cfg_i.period),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Next state and strobes.
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      pctb_pkg::S_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if ((item_i.op == pctb_pkg::OP_TAKE) || (item_i.op == pctb_pkg::OP_REFUND)) begin
            if (valid_q[in_idx]) begin
              ram_re  = 1'b1;
              state_d = pctb_pkg::S_READ;
            end else if (item_i.op == pctb_pkg::OP_TAKE) begin
              state_d = pctb_pkg::S_GRANT;
            end
          end
        end
      end
      pctb_pkg::S_READ: begin
        state_d = (op_q == pctb_pkg::OP_TAKE) ? pctb_pkg::S_MUL : pctb_pkg::S_GRANT;
      end
      pctb_pkg::S_MUL: begin
        div_start = 1'b1;
        state_d   = pctb_pkg::S_DIV;
      end
      pctb_pkg::S_DIV: begin
        if (div_done) begin
          state_d = pctb_pkg::S_APPLY;
        end
      end
      pctb_pkg::S_APPLY: begin
        state_d = pctb_pkg::S_GRANT;
      end
      pctb_pkg::S_GRANT: begin
        ram_we  = 1'b1;
        state_d = pctb_pkg::S_IDLE;
      end
      default: begin
        state_d = pctb_pkg::S_IDLE;
      end
    endcase
  end

  // Control state: sequencer, valid bits and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pctb_pkg::S_IDLE;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == pctb_pkg::S_IDLE && item_valid_i) begin
        case (item_i.op)
          pctb_pkg::OP_CLEAR: begin
            valid_q <= '0;
            done_q  <= 1'b1;
          end
          pctb_pkg::OP_TAKE: begin
            valid_q[in_idx] <= 1'b1;
          end
          pctb_pkg::OP_REFUND: begin
            done_q <= !valid_q[in_idx];
          end
          default: begin
            done_q <= 1'b1;
          end
        endcase
      end
      if (state_q == pctb_pkg::S_GRANT) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      pctb_pkg::S_IDLE: begin
        op_q      <= item_i.op;
        idx_q     <= in_idx;
        now_q     <= item_i.now_ms;
        amt_q     <= item_i.amount;
        tok_q     <= cfg_i.capacity;
        stamp_q   <= item_i.now_ms;
        granted_q <= '0;
        left_q    <= '0;
      end
      pctb_pkg::S_READ: begin
        stamp_q <= rd_stamp;
        prod_q  <= PW'(elapsed) * PW'(cfg_i.capacity);
        if (op_q == pctb_pkg::OP_REFUND) begin
          tok_q <= pctb_pkg::top_up(rd_tok, PW'(amt_q), cfg_i.capacity);
        end else begin
          tok_q <= rd_tok;
        end
      end
      pctb_pkg::S_APPLY: begin
        if (quot != '0) begin
          tok_q   <= pctb_pkg::top_up(tok_q, quot, cfg_i.capacity);
          stamp_q <= now_q;
        end
      end
      pctb_pkg::S_GRANT: begin
        granted_q <= grant;
        left_q    <= tok_q - grant;
      end
      default: begin
      end
    endcase
  end

  assign done_o        = done_q;
  assign granted_o     = granted_q;
  assign tokens_left_o = left_q;

endmodule

`default_nettype wire

[rtl/per_channel_token_bucket_top.sv]
// Top level of the per-channel token bucket: configuration registers and the two engine halves.
//
// Usage: a command word (command_i, channel_i, now_ms_i, amount_i) is taken at a rising
// edge where start is high and busy is low. Commands are take (refill, then grant),
// refund, and clear of all buckets. Every command gives one result word on granted_o and
// tokens_left_o, marked by a one-cycle done_o pulse; results come back in command order.
// A two-entry queue sits between the command side and the execution engine, so busy is
// high only while that queue is full.
// Clear, ignored commands and refunds to a fresh bucket are answered straight from the
// idle state; the first take on a bucket goes to the grant state; a refund reads the
// table, then grants; a take on a live bucket reads, multiplies, runs the bit-serial refill
// divider, applies the refill and grants. The queue takes new commands while the engine works.
// The APB port holds bucket_capacity at 0x0 and refill_period_ms at 0x4; write it only
// while no command is outstanding. pready is tied high.
// Reset clears the queue, the sequencer and every bucket's valid bit, and restores the
// register defaults; the bucket table itself needs no clearing pass.
// The receiver cannot stall: each result is valid only in its done_o cycle.
`default_nettype none

module per_channel_token_bucket_top #(
  parameter int unsigned CHANNEL_COUNT = pctb_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Command channel.
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [pctb_pkg::CMD_W-1:0]    command_i,
  input  wire logic [pctb_pkg::CH_W-1:0]     channel_i,
  input  wire logic [pctb_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic [pctb_pkg::TOK_W-1:0]    amount_i,
  // Result channel.
  output      logic                          done_o,
  output      logic [pctb_pkg::TOK_W-1:0]    granted_o,
  output      logic [pctb_pkg::TOK_W-1:0]    tokens_left_o,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pctb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pctb_pkg::PDATA_W-1:0]  pwdata,
  output      logic [pctb_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready
);

  logic [pctb_pkg::TOK_W-1:0]  cap_q;
  logic [pctb_pkg::TIME_W-1:0] period_q;
  pctb_pkg::reg_e              reg_sel;
  logic                        cfg_wr;
  pctb_pkg::cfg_t              cfg;
  pctb_pkg::item_t             item;
  logic                        item_valid;
  logic                        pop;

  // Register decode; each register is word aligned.
  assign reg_sel = pctb_pkg::reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= pctb_pkg::CAP_RESET;
      period_q <= pctb_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        pctb_pkg::REG_CAPACITY: cap_q    <= pwdata[pctb_pkg::TOK_W-1:0];
        pctb_pkg::REG_PERIOD:   period_q <= pwdata[pctb_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      pctb_pkg::REG_CAPACITY: prdata = pctb_pkg::PDATA_W'(cap_q);
      pctb_pkg::REG_PERIOD:   prdata = pctb_pkg::PDATA_W'(period_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg = '{capacity: cap_q, period: period_q};

  // Command intake and queue.
  pctb_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .channel_i    (channel_i),
    .now_ms_i     (now_ms_i),
    .amount_i     (amount_i),
    .pop_i        (pop),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  // Bucket engine.
  pctb_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .pop_o         (pop),
    .done_o        (done_o),
    .granted_o     (granted_o),
    .tokens_left_o (tokens_left_o)
  );

endmodule

`default_nettype wire

[rtl/pctb_checker.sv]
// Port-level checker for the token bucket top level, with its bind statement.
`default_nettype none

module pctb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [pctb_pkg::CMD_W-1:0]    command_i,
  input wire logic                          done_o,
  input wire logic [pctb_pkg::TOK_W-1:0]    granted_o,
  input wire logic                          pready
);

  localparam int unsigned OUT_W = $clog2(pctb_pkg::QUEUE_DEPTH + 2) + 1;

  logic [OUT_W-1:0] pending_q;
  logic             accept;

  // Words accepted but not yet answered.
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (accept && !done_o) begin
      pending_q <= pending_q + OUT_W'(1);
    end else if (done_o && !accept) begin
      pending_q <= pending_q - OUT_W'(1);
    end
  end

  // A result only answers a word that was taken.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pending_q != '0))
    else $error("result strobe with no command outstanding");

  // Backpressure only appears while the queue holds work.
  a_busy_only_with_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (pending_q != '0))
    else $error("busy raised with nothing outstanding");

  // A clear, refund or ignored command taken by an idle block never grants; the check covers
  // the cycle in which the quick answer to it arrives.
  a_grant_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i != pctb_pkg::CMD_TAKE) && (pending_q == '0)) |=>
      ##1 (!done_o || (granted_o == '0)))
    else $error("tokens granted for a command other than take");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind per_channel_token_bucket_top pctb_checker u_pctb_checker (.*);

`default_nettype wire
